// File: design/pinch_zoom_detector_assert.svh
// ----------------------------------------------------------------------------
// pinch_zoom_detector_assert
// assertion macros used by the pinch zoom detector module
// ----------------------------------------------------------------------------
`ifndef PINCH_ZOOM_DETECTOR_ASSERT_SVH
`define PINCH_ZOOM_DETECTOR_ASSERT_SVH

// same-cycle implication, clocked on clk, idle during rst
`define PZD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, idle during rst
`define PZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pzd_pkg.sv
// ----------------------------------------------------------------------------
// pzd_pkg
// widths, reset values and codes of the pinch zoom detector
// ----------------------------------------------------------------------------
package pzd_pkg;

  // payload widths
  localparam int MODE_W     = 3;
  localparam int DEV_W      = 4;
  localparam int POS_W      = 16;
  localparam int DIST_W     = 17;
  localparam int RAD_W      = 34;
  localparam int PINCH_W    = 32;
  localparam int HOLD_W     = 16;
  localparam int FACTOR_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;

  // default slot count
  localparam int DEVICES_DEF = 16;

  // configuration reset values
  localparam logic [HOLD_W-1:0]   HOLD_RANGE_RST   = 16'd80;
  localparam logic [FACTOR_W-1:0] TOUCH_FACTOR_RST = 8'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RANGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PINCH_INHIBIT = 2'd2;

  // event mode codes
  localparam logic [MODE_W-1:0] MODE_PRI_DOWN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRI_UP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEC_DOWN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEC_UP     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEC_MOVE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_JOB_RUN    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PLAN_RESET = 3'd6;

  // zoom plan
  typedef enum logic [1:0] {
    PLAN_NONE = 2'd0,
    PLAN_OUT  = 2'd1,
    PLAN_IN   = 2'd2
  } plan_t;

endpackage

// File: design/pzd_isqrt.sv
// ----------------------------------------------------------------------------
// pzd_isqrt
// bit-serial floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module pzd_isqrt import pzd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  localparam int STEPS = RAD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad_sh;
  logic [DIST_W:0]  rem;

  logic [DIST_W+2:0] rem_sh;
  logic [DIST_W+2:0] trial;
  logic [DIST_W+2:0] rem_sub;
  logic              take;

  // one restoring step: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem_sh  = {rem, rad_sh[RAD_W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    take    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(STEPS);
        rad_sh <= radicand;
        rem    <= '0;
        root   <= '0;
      end else if (busy) begin
        rem    <= take ? rem_sub[DIST_W:0] : rem_sh[DIST_W:0];
        root   <= {root[DIST_W-2:0], take};
        rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/pinch_zoom_detector.sv
// ----------------------------------------------------------------------------
// pinch_zoom_detector
// two-finger pinch detector: slot tracking, distance, zoom planning and jobs
// ----------------------------------------------------------------------------
// path: an event without a distance passes ST_EXEC and ST_FIN to the result word
// path: a secondary move with the primary finger down adds ST_MUL_X, ST_MUL_Y
//   (two squares on one multiplier), ST_SUM, ST_ROOT (the 17-step bit-serial
//   square root) and ST_DECIDE; one event at a time, and the
//   next word is taken the cycle after the result moves into the output register
// reset: slots free, plan none, no job, hold range 80, touch factor 4
// ----------------------------------------------------------------------------
`include "pinch_zoom_detector_assert.svh"

module pinch_zoom_detector import pzd_pkg::*; #(
  parameter int DEVICES = DEVICES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // mode[2:0], device[6:3], pos_x[22:7], pos_y[38:23], zero[39]
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // zoom_out[0], zoom_in[1], distance[18:2], accepted[19], zero[23:20]
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W   = $clog2(DEVICES);
  localparam int PROD_W   = PINCH_W + POS_W + 2;
  localparam int FPROD_W  = PINCH_W + FACTOR_W + 1;
  localparam int DIFF_W   = DIST_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL_X, ST_MUL_Y, ST_SUM, ST_ROOT, ST_DECIDE, ST_FIN
  } state_t;

  state_t state;

  // configuration
  logic [HOLD_W-1:0]   hold_range;
  logic [FACTOR_W-1:0] touch_factor;
  logic                pinch_inhibit;

  // tracking state
  logic [DEVICES-1:0]        slot_valid;
  logic signed [POS_W-1:0]   prim_x;
  logic signed [POS_W-1:0]   prim_y;
  logic signed [PINCH_W-1:0] pinch_mem [DEVICES];
  logic signed [PINCH_W-1:0] pinch_rd;
  logic [DIST_W-1:0]         last_distance;
  logic signed [PINCH_W-1:0] saved_pinch;
  plan_t                     zoom_plan;
  logic                      job_pending;
  logic                      job_is_in;

  // held event
  logic [MODE_W-1:0]       item_mode;
  logic [DEV_W-1:0]        item_dev;
  logic signed [POS_W-1:0] item_x;
  logic signed [POS_W-1:0] item_y;

  // arithmetic
  logic signed [PROD_W-1:0] prod;
  logic [RAD_W-1:0]         sq;

  // result staging
  logic              res_zo;
  logic              res_zi;
  logic [DIST_W-1:0] res_dist;
  logic              res_acc;

  logic              sq_done;
  logic [DIST_W-1:0] sq_root;

  // slot addressing
  logic [SLOT_W-1:0] slot_idx;
  logic              dev_ok;
  logic              slot_held;

  always_comb begin
    slot_idx  = SLOT_W'(item_dev);
    dev_ok    = (int'(item_dev) < DEVICES);
    slot_held = dev_ok && slot_valid[slot_idx];
  end

  // shared multiplier operands
  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic signed [PINCH_W:0] mul_a;
  logic signed [POS_W:0]   mul_b;

  always_comb begin
    dx = {prim_x[POS_W-1], prim_x} - {item_x[POS_W-1], item_x};
    dy = {prim_y[POS_W-1], prim_y} - {item_y[POS_W-1], item_y};
    case (state)
      ST_MUL_X: begin
        mul_a = {{(PINCH_W-POS_W){dx[POS_W]}}, dx};
        mul_b = dx;
      end
      ST_MUL_Y: begin
        mul_a = {{(PINCH_W-POS_W){dy[POS_W]}}, dy};
        mul_b = dy;
      end
      default: begin
        mul_a = {saved_pinch[PINCH_W-1], saved_pinch};
        mul_b = $signed({{(POS_W+1-FACTOR_W){1'b0}}, touch_factor});
      end
    endcase
  end

  // square root unit
  logic             sq_start;
  logic [RAD_W-1:0] radicand;

  always_comb begin
    sq_start = (state == ST_SUM);
    radicand = sq + prod[RAD_W-1:0];
  end

  pzd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // pinch decision after the distance is known
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PINCH_W:0]   pinch_w;
  logic signed [PINCH_W:0]   hold_s;
  logic signed [FPROD_W-1:0] fprod;
  logic signed [FPROD_W-1:0] pinch_f;
  logic                      saved_nz;
  logic                      fire_out;
  logic                      fire_in;
  logic signed [PINCH_W:0]   pinch_sum;
  logic signed [PINCH_W-1:0] pinch_new;

  always_comb begin
    diff     = $signed({1'b0, last_distance}) - $signed({1'b0, sq_root});
    pinch_w  = {pinch_rd[PINCH_W-1], pinch_rd};
    hold_s   = $signed({{(PINCH_W+1-HOLD_W){1'b0}}, hold_range});
    fprod    = prod[FPROD_W-1:0];
    pinch_f  = {{(FPROD_W-PINCH_W){pinch_rd[PINCH_W-1]}}, pinch_rd};
    saved_nz = (saved_pinch != '0);
    fire_out = (diff > 0) && (pinch_w > hold_s) && !(saved_nz && (pinch_f < fprod));
    fire_in  = (diff < 0) && (pinch_w < -hold_s) && !(saved_nz && (pinch_f > fprod));
    pinch_sum = ((fire_out || fire_in) ? '0 : pinch_w)
              + {{(PINCH_W+1-DIFF_W){diff[DIFF_W-1]}}, diff};
    if (pinch_sum[PINCH_W] != pinch_sum[PINCH_W-1]) begin
      pinch_new = pinch_sum[PINCH_W] ? {1'b1, {(PINCH_W-1){1'b0}}}
                                     : {1'b0, {(PINCH_W-1){1'b1}}};
    end else begin
      pinch_new = pinch_sum[PINCH_W-1:0];
    end
  end

  // pinch memory write port
  logic                      mem_we;
  logic signed [PINCH_W-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (state == ST_EXEC) begin
      case (item_mode)
        MODE_PRI_DOWN, MODE_SEC_DOWN: mem_we = dev_ok && !slot_valid[slot_idx];
        MODE_PRI_UP, MODE_SEC_UP:     mem_we = slot_held;
        default:                      mem_we = 1'b0;
      endcase
    end else if (state == ST_DECIDE) begin
      mem_we    = (last_distance != '0);
      mem_wdata = pinch_new;
    end
  end

  // pinch memory, registered read at the held slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pinch_mem[slot_idx] <= mem_wdata;
    end
    pinch_rd <= pinch_mem[slot_idx];
  end

  // handshakes
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer, tracking state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hold_range    <= HOLD_RANGE_RST;
      touch_factor  <= TOUCH_FACTOR_RST;
      pinch_inhibit <= 1'b0;
      slot_valid    <= '0;
      last_distance <= '0;
      saved_pinch   <= '0;
      zoom_plan     <= PLAN_NONE;
      job_pending   <= 1'b0;
      job_is_in     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HOLD_RANGE:    hold_range    <= cfg_data[HOLD_W-1:0];
          CFG_TOUCH_FACTOR:  touch_factor  <= cfg_data[FACTOR_W-1:0];
          CFG_PINCH_INHIBIT: pinch_inhibit <= cfg_data[0];
          default:           ;
        endcase
      end

      // output word taken; a word loaded from the final state refills it
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_mode <= s_tdata[2:0];
            item_dev  <= (s_tdata[2:0] == MODE_PRI_DOWN || s_tdata[2:0] == MODE_PRI_UP)
                         ? '0 : s_tdata[6:3];
            item_x    <= s_tdata[22:7];
            item_y    <= s_tdata[38:23];
            state     <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res_zo   <= 1'b0;
          res_zi   <= 1'b0;
          res_dist <= '0;
          res_acc  <= 1'b0;
          state    <= ST_FIN;
          case (item_mode)
            MODE_PRI_DOWN, MODE_SEC_DOWN: begin
              if (dev_ok && !slot_valid[slot_idx]) begin
                slot_valid[slot_idx] <= 1'b1;
                if (slot_idx == '0) begin
                  prim_x <= item_x;
                  prim_y <= item_y;
                end
                res_acc <= 1'b1;
              end
            end
            MODE_PRI_UP: begin
              if (slot_held) begin
                slot_valid[slot_idx] <= 1'b0;
                res_acc              <= 1'b1;
              end
            end
            MODE_SEC_UP: begin
              if (slot_held) begin
                last_distance        <= '0;
                saved_pinch          <= '0;
                slot_valid[slot_idx] <= 1'b0;
                res_acc              <= 1'b1;
              end
            end
            MODE_SEC_MOVE: begin
              if (slot_held && !pinch_inhibit) begin
                if (slot_idx == '0) begin
                  prim_x <= item_x;
                  prim_y <= item_y;
                end
                res_acc <= 1'b1;
                if (slot_valid[0]) begin
                  state <= ST_MUL_X;
                end
              end
            end
            MODE_JOB_RUN: begin
              if (job_pending) begin
                res_zi      <= job_is_in && (zoom_plan == PLAN_IN);
                res_zo      <= !job_is_in && (zoom_plan == PLAN_OUT);
                job_pending <= 1'b0;
                job_is_in   <= 1'b0;
                res_acc     <= 1'b1;
              end
            end
            MODE_PLAN_RESET: begin
              job_pending <= 1'b0;
              job_is_in   <= 1'b0;
              zoom_plan   <= PLAN_NONE;
              res_acc     <= 1'b1;
            end
            default: ;
          endcase
        end

        // squares of the offsets on the shared multiplier
        ST_MUL_X: begin
          prod  <= mul_a * mul_b;
          state <= ST_MUL_Y;
        end

        ST_MUL_Y: begin
          sq    <= prod[RAD_W-1:0];
          prod  <= mul_a * mul_b;
          state <= ST_SUM;
        end

        // root starts; multiplier forms the suppression bound
        ST_SUM: begin
          prod  <= mul_a * mul_b;
          state <= ST_ROOT;
        end

        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          res_dist <= sq_root;
          if (last_distance != '0 && (fire_out || fire_in)) begin
            zoom_plan   <= fire_in ? PLAN_IN : PLAN_OUT;
            saved_pinch <= pinch_rd;
            if (!job_pending) begin
              job_pending <= 1'b1;
              job_is_in   <= fire_in;
            end
          end
          last_distance <= sq_root;
          state         <= ST_FIN;
        end

        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{(M_TDATA_W-DIST_W-3){1'b0}}, res_acc, res_dist, res_zi, res_zo};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `PZD_ASSERT_NOW(a_root_done_in_wait, sq_done, state == ST_ROOT, "root done outside wait")
  `PZD_ASSERT_NOW(a_job_kind_needs_job, job_is_in, job_pending, "job kind set without job")
  `PZD_ASSERT_NOW(a_zoom_is_accepted, m_tvalid && (m_tdata[0] || m_tdata[1]), m_tdata[19],
                  "zoom fired on an ignored event")
  `PZD_ASSERT_NOW(a_one_zoom, m_tvalid, !(m_tdata[0] && m_tdata[1]), "zoom in and out together")
  `PZD_ASSERT_NEXT(a_decide_to_fin, state == ST_DECIDE, state == ST_FIN,
                   "decision not followed by result")

endmodule

// File: test/pinch_zoom_checker.sv
// ----------------------------------------------------------------------------
// pinch_zoom_checker
// watches the event, result and register channels of the pinch zoom detector,
// keeps its own copy of the slot, plan and job state, works out the result
// word of every accepted event and compares it field by field
// ----------------------------------------------------------------------------
module pinch_zoom_checker import pzd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    zooms_fired,
  output int                    distances_measured
);

  localparam int SLOTS      = DEVICES_DEF;
  localparam int REPORT_MAX = 10;
  localparam longint PINCH_MAX = 64'sd2147483647;
  localparam longint PINCH_MIN = -64'sd2147483648;

  typedef struct packed {
    logic              zoom_out;
    logic              zoom_in;
    logic [DIST_W-1:0] distance;
    logic              accepted;
  } touch_result_t;

  // tracked touch state
  logic [SLOTS-1:0]           held;
  logic signed [POS_W-1:0]    finger_x [SLOTS];
  logic signed [POS_W-1:0]    finger_y [SLOTS];
  logic signed [PINCH_W-1:0]  pinch_acc [SLOTS];
  logic [DIST_W-1:0]          prev_distance;
  logic signed [PINCH_W-1:0]  pinch_at_plan;
  plan_t                      plan;
  logic                       job_queued;
  logic                       job_zoom_in;

  // register copies
  logic [HOLD_W-1:0]          hold_range;
  logic [FACTOR_W-1:0]        factor;
  logic                       inhibit;

  touch_result_t              pending_results [$];
  int                         bad_count;
  int                         zoom_count;
  int                         dist_count;

  function automatic logic [DIST_W-1:0] floor_sqrt(input longint radicand);
    logic [DIST_W-1:0] root;
    longint            trial;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = longint'(root) + (longint'(1) << b);
      if (trial * trial <= radicand) root = DIST_W'(trial);
    end
    return root;
  endfunction

  function automatic logic signed [PINCH_W-1:0] clip_pinch(input longint v);
    if (v > PINCH_MAX) return PINCH_W'(PINCH_MAX);
    if (v < PINCH_MIN) return PINCH_W'(PINCH_MIN);
    return PINCH_W'(v);
  endfunction

  function automatic void queue_zoom(input plan_t which);
    plan = which;
    if (!job_queued) begin
      job_queued  = 1'b1;
      job_zoom_in = (which == PLAN_IN);
    end
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < SLOTS; i++) begin
      finger_x[i]  = '0;
      finger_y[i]  = '0;
      pinch_acc[i] = '0;
    end
    held          = '0;
    prev_distance = '0;
    pinch_at_plan = '0;
    plan          = PLAN_NONE;
    job_queued    = 1'b0;
    job_zoom_in   = 1'b0;
    hold_range    = HOLD_RANGE_RST;
    factor        = TOUCH_FACTOR_RST;
    inhibit       = 1'b0;
  endfunction

  function automatic void take_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_HOLD_RANGE:    hold_range = value[HOLD_W-1:0];
      CFG_TOUCH_FACTOR:  factor = value[FACTOR_W-1:0];
      CFG_PINCH_INHIBIT: inhibit = value[0];
      default: ;
    endcase
  endfunction

  // secondary move: store position, measure, accumulate and maybe plan a zoom
  function automatic logic finger_move(input int slot,
                                       input logic signed [POS_W-1:0] x,
                                       input logic signed [POS_W-1:0] y,
                                       output logic [DIST_W-1:0] moved_dist);
    longint            dx;
    longint            dy;
    longint            diff;
    longint            pinch;
    longint            limit;
    logic [DIST_W-1:0] dnew;
    moved_dist = '0;
    if (inhibit) return 1'b0;
    finger_x[slot] = x;
    finger_y[slot] = y;
    if (!held[0]) return 1'b1;
    dx   = longint'(finger_x[0]) - longint'(x);
    dy   = longint'(finger_y[0]) - longint'(y);
    dnew = floor_sqrt(dx * dx + dy * dy);
    moved_dist = dnew;
    if (prev_distance != '0) begin
      diff  = longint'(prev_distance) - longint'(dnew);
      pinch = longint'(pinch_acc[slot]);
      limit = longint'(pinch_at_plan) * longint'(factor);
      if (diff > 0 && pinch > longint'(hold_range)) begin
        // fingers closing: zoom out unless the last pinch still suppresses it
        if (!(pinch_at_plan != '0 && pinch < limit)) begin
          queue_zoom(PLAN_OUT);
          pinch_at_plan = PINCH_W'(pinch);
          pinch = 0;
        end
      end else if (diff < 0 && pinch < -longint'(hold_range)) begin
        // fingers opening: zoom in
        if (!(pinch_at_plan != '0 && pinch > limit)) begin
          queue_zoom(PLAN_IN);
          pinch_at_plan = PINCH_W'(pinch);
          pinch = 0;
        end
      end
      pinch_acc[slot] = clip_pinch(pinch + diff);
    end
    prev_distance = dnew;
    return 1'b1;
  endfunction

  function automatic touch_result_t predict_touch(input logic [MODE_W-1:0] mode,
                                                  input logic [DEV_W-1:0] dev,
                                                  input logic signed [POS_W-1:0] x,
                                                  input logic signed [POS_W-1:0] y);
    touch_result_t     r;
    int                slot;
    logic [DIST_W-1:0] move_dist;
    r         = '0;
    move_dist = '0;
    slot = (mode == MODE_PRI_DOWN || mode == MODE_PRI_UP) ? 0 : int'(dev);
    case (mode)
      MODE_PRI_DOWN, MODE_SEC_DOWN: begin
        if (!held[slot]) begin
          held[slot]      = 1'b1;
          finger_x[slot]  = x;
          finger_y[slot]  = y;
          pinch_acc[slot] = '0;
          r.accepted      = 1'b1;
        end
      end
      MODE_PRI_UP: begin
        if (held[0]) begin
          held[0]      = 1'b0;
          pinch_acc[0] = '0;
          r.accepted   = 1'b1;
        end
      end
      MODE_SEC_UP: begin
        if (held[slot]) begin
          prev_distance   = '0;
          pinch_at_plan   = '0;
          held[slot]      = 1'b0;
          pinch_acc[slot] = '0;
          r.accepted      = 1'b1;
        end
      end
      MODE_SEC_MOVE: begin
        if (held[slot]) r.accepted = finger_move(slot, x, y, move_dist);
      end
      MODE_JOB_RUN: begin
        // a job fires only while the plan still agrees with its kind
        if (job_queued) begin
          if (job_zoom_in) r.zoom_in = (plan == PLAN_IN);
          else r.zoom_out = (plan == PLAN_OUT);
          job_queued  = 1'b0;
          job_zoom_in = 1'b0;
          r.accepted  = 1'b1;
        end
      end
      MODE_PLAN_RESET: begin
        job_queued  = 1'b0;
        job_zoom_in = 1'b0;
        plan        = PLAN_NONE;
        r.accepted  = 1'b1;
      end
      default: ;
    endcase
    r.distance = move_dist;
    return r;
  endfunction

  // sample all three channels at the clock edge
  always @(posedge clk) begin : track
    touch_result_t got;
    touch_result_t want;
    if (rst) begin
      clear_model();
      pending_results.delete();
      bad_count  = 0;
      zoom_count = 0;
      dist_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) take_register(cfg_index, cfg_data);

      // result word against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.zoom_out = m_tdata[0];
        got.zoom_in  = m_tdata[1];
        got.distance = m_tdata[2 +: DIST_W];
        got.accepted = m_tdata[2 + DIST_W];
        if (pending_results.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX)
            $display("unexpected result word: out=%0d in=%0d dist=%0d acc=%0d",
                     got.zoom_out, got.zoom_in, got.distance, got.accepted);
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            bad_count++;
            if (bad_count <= REPORT_MAX)
              $display("result mismatch: want out=%0d in=%0d dist=%0d acc=%0d, got out=%0d in=%0d dist=%0d acc=%0d",
                       want.zoom_out, want.zoom_in, want.distance, want.accepted,
                       got.zoom_out, got.zoom_in, got.distance, got.accepted);
          end
          if (want.zoom_out || want.zoom_in) zoom_count++;
        end
      end

      // event word into the predictor
      if (s_tvalid && s_tready) begin
        want = predict_touch(s_tdata[MODE_W-1:0], s_tdata[MODE_W +: DEV_W],
                             s_tdata[MODE_W + DEV_W +: POS_W],
                             s_tdata[MODE_W + DEV_W + POS_W +: POS_W]);
        if (want.distance != '0) dist_count++;
        pending_results.push_back(want);
      end
    end
    mismatches         <= bad_count;
    outstanding        <= pending_results.size();
    zooms_fired        <= zoom_count;
    distances_measured <= dist_count;
  end

endmodule

// File: test/pinch_zoom_detector_test.sv
// ----------------------------------------------------------------------------
// pinch_zoom_detector_test
// drives touch events and register writes into the pinch zoom detector: a
// short directed pass over the corner cases, then random pinch gestures mixed
// with noise under six register settings and three idling mixes; the checker
// beside the block scores every result word
// ----------------------------------------------------------------------------
module pinch_zoom_detector_test;
  import pzd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  wire                   s_tready;
  wire  [M_TDATA_W-1:0]  m_tdata;
  wire                   m_tvalid;
  wire                   cfg_ready;

  int mismatches;
  int outstanding;
  int zooms_fired;
  int distances_measured;
  int send_idle      = 0;
  int recv_idle      = 0;
  int hold_off_asked = 0;
  int hold_off_done  = 0;
  int hold_off_left  = 0;
  int quiet_cycles   = 0;
  int events_sent    = 0;

  pinch_zoom_detector dut (
    .clk, .rst,
    .s_tdata, .s_tvalid, .s_tready,
    .m_tdata, .m_tvalid, .m_tready,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pinch_zoom_checker pinch_check (
    .clk, .rst,
    .s_tdata, .s_tvalid, .s_tready,
    .m_tdata, .m_tvalid, .m_tready,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .zooms_fired, .distances_measured
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      m_tready      <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_done != hold_off_asked) begin
      m_tready      <= 1'b0;
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_done <= hold_off_asked;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_pos(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_pos();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 32767 : -32768;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // push an offset away from (or toward) the primary finger
  function automatic int spread(input int o, input int d);
    int v;
    v = (o >= 0) ? o + d : o - d;
    if (v > 40000) v = 40000;
    if (v < -40000) v = -40000;
    return v;
  endfunction

  task automatic send_touch(input logic [MODE_W-1:0] mode, input int dev,
                            input int x, input int y);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, POS_W'(y), POS_W'(x), DEV_W'(dev), mode};
    do @(posedge clk); while (!s_tready);
    events_sent++;
  endtask

  task automatic send_noise();
    send_touch(MODE_W'($urandom_range(7)), $urandom_range(15), $urandom(), $urandom());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // one primary finger, one or two secondary fingers, a run of trending moves
  task automatic pinch_gesture();
    int dev_of [2];
    int ox [2];
    int oy [2];
    int px;
    int py;
    int fingers;
    int dir;
    int moves;
    int step;
    int f;
    px = rand_pos();
    py = rand_pos();
    send_touch(MODE_PRI_DOWN, $urandom_range(15), px, py);
    fingers = $urandom_range(1, 2);
    for (int i = 0; i < fingers; i++) begin
      dev_of[i] = $urandom_range(1, 15);
      ox[i]     = int'($urandom_range(32000)) - 16000;
      oy[i]     = int'($urandom_range(32000)) - 16000;
      send_touch(MODE_SEC_DOWN, dev_of[i], clamp_pos(px + ox[i]), clamp_pos(py + oy[i]));
    end
    dir   = $urandom_range(1) ? 1 : -1;
    moves = $urandom_range(4, 18);
    for (int k = 0; k < moves; k++) begin
      if ($urandom_range(9) == 0) dir = -dir;
      f    = $urandom_range(fingers - 1);
      step = ($urandom_range(3) == 0) ? $urandom_range(20000) : $urandom_range(1500);
      if ($urandom_range(19) == 0) begin
        // primary finger moves through its own slot
        px = clamp_pos(px + int'($urandom_range(200)) - 100);
        send_touch(MODE_SEC_MOVE, 0, px, py);
      end else begin
        ox[f] = spread(ox[f], dir * step);
        oy[f] = spread(oy[f], dir * step / 2);
        send_touch(MODE_SEC_MOVE, dev_of[f], clamp_pos(px + ox[f]), clamp_pos(py + oy[f]));
      end
      if ($urandom_range(5) == 0)
        send_touch(MODE_JOB_RUN, $urandom_range(15), $urandom(), $urandom());
      else if ($urandom_range(29) == 0)
        send_touch(MODE_PLAN_RESET, $urandom_range(15), $urandom(), $urandom());
      else if ($urandom_range(11) == 0)
        send_noise();
    end
    send_touch(MODE_JOB_RUN, $urandom_range(15), $urandom(), $urandom());
    for (int i = 0; i < fingers; i++)
      if ($urandom_range(7) != 0) send_touch(MODE_SEC_UP, dev_of[i], $urandom(), $urandom());
    if ($urandom_range(7) != 0) send_touch(MODE_PRI_UP, $urandom_range(15), $urandom(), $urandom());
  endtask

  task automatic run_segment(input int hold, input int fac, input bit inhibit,
                             input int tx_idle, input int rx_idle, input int budget,
                             input bit hold_off, input bit pause_mid);
    int start;
    wait_drained();
    write_register(CFG_HOLD_RANGE, hold);
    write_register(CFG_TOUCH_FACTOR, fac);
    write_register(CFG_PINCH_INHIBIT, inhibit);
    cfg_valid <= 1'b0;
    send_idle = tx_idle;
    recv_idle = rx_idle;
    start     = events_sent;
    while (events_sent - start < budget) begin
      if (events_sent - start >= budget / 2) begin
        // receiver stalls while events keep coming
        if (hold_off) begin
          hold_off_asked++;
          hold_off = 1'b0;
        end
        // sender waits until every result is back
        if (pause_mid) begin
          wait_drained();
          pause_mid = 1'b0;
        end
      end
      pinch_gesture();
      repeat ($urandom_range(3)) send_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst       <= 1'b0;
    send_idle = 27;
    recv_idle = 56;

    // directed corner cases under reset registers
    send_touch(MODE_JOB_RUN, 0, 0, 0);                  // no job queued
    send_touch(MODE_PRI_UP, 9, 0, 0);                   // primary not down
    send_touch(MODE_SEC_MOVE, 3, 5, 5);                 // move on a free slot
    send_touch(MODE_SEC_UP, 3, 0, 0);                   // up on a free slot
    send_touch(MODE_UNUSED, 15, -1, -1);                // unused mode code
    send_touch(MODE_PLAN_RESET, 0, 0, 0);
    send_touch(MODE_SEC_DOWN, 3, 32767, 32767);
    send_touch(MODE_SEC_MOVE, 3, -1, -1);               // no primary: stored, no distance
    send_touch(MODE_PRI_DOWN, 5, -32768, -32768);       // device field ignored
    send_touch(MODE_PRI_DOWN, 0, 0, 0);                 // down on a held slot
    send_touch(MODE_SEC_DOWN, 3, 0, 0);                 // down on a held slot
    send_touch(MODE_SEC_MOVE, 3, 32767, 32767);         // widest distance
    send_touch(MODE_SEC_MOVE, 3, 0, 0);                 // closing
    send_touch(MODE_SEC_MOVE, 3, -32700, -32700);       // closing past hold: zoom out planned
    send_touch(MODE_SEC_MOVE, 3, -16384, -16384);       // opening steps re-plan to zoom in
    send_touch(MODE_SEC_MOVE, 3, 0, 0);
    send_touch(MODE_SEC_MOVE, 3, 16384, 16384);
    send_touch(MODE_SEC_MOVE, 3, 32767, 32767);
    send_touch(MODE_JOB_RUN, 7, 1, 1);                  // queued out job, plan now in
    send_touch(MODE_SEC_MOVE, 0, -32768, -32768);       // primary measured against itself
    send_touch(MODE_SEC_UP, 3, 0, 0);
    send_touch(MODE_PRI_UP, 0, 0, 0);

    // random gestures under several register settings and idling mixes
    run_segment(80, 4, 1'b0, 27, 56, 150, 1'b1, 1'b0);
    run_segment(0, 0, 1'b0, 27, 56, 140, 1'b0, 1'b0);
    run_segment(300, 255, 1'b0, 56, 27, 140, 1'b0, 1'b1);
    run_segment(25, 2, 1'b1, 56, 27, 70, 1'b0, 1'b0);
    run_segment(65535, 255, 1'b0, 0, 0, 140, 1'b0, 1'b0);
    run_segment(120, 3, 1'b0, 0, 0, 140, 1'b1, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d touch events over six register settings and three idling mixes",
             events_sent);
    $display("%0d finger distances measured, %0d zooms fired, %0d mismatches",
             distances_measured, zooms_fired, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/pzd_pkg.sv
design/pzd_isqrt.sv
design/pinch_zoom_detector.sv
test/pinch_zoom_checker.sv
test/pinch_zoom_detector_test.sv
